// ===== hw/rtl/ugsd_pkg.sv =====
// ----------------------------------------------------------------------------
// ugsd_pkg
// Shared types and constants for the UTF-8 glyph stream decoder.
// ----------------------------------------------------------------------------
package ugsd_pkg;

  localparam int unsigned CpW      = 16;
  localparam int unsigned CountW   = 9;
  localparam int unsigned IndexW   = 8;
  localparam int unsigned PartialW = 10;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_STRIP_A_FIRST = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STRIP_A_COUNT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_STRIP_B_FIRST = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_STRIP_B_COUNT = 2'd3;

  // Configuration reset values.
  localparam logic [CpW-1:0]    STRIP_A_FIRST_RST = 16'h0020;
  localparam logic [CountW-1:0] STRIP_A_COUNT_RST = 9'd96;
  localparam logic [CpW-1:0]    STRIP_B_FIRST_RST = 16'h0400;
  localparam logic [CountW-1:0] STRIP_B_COUNT_RST = 9'd96;

  // Largest strip size honored.
  localparam logic [CountW-1:0] STRIP_MAX = 9'd256;

  // Byte classes of UTF-8.
  localparam logic [7:0] LEAD2_BASE = 8'hC0;
  localparam logic [7:0] LEAD3_BASE = 8'hE0;
  localparam logic [7:0] LEAD4_BASE = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;

  typedef enum logic [1:0] {
    CLS_STRIP_A = 2'd0,
    CLS_STRIP_B = 2'd1,
    CLS_UNSUP   = 2'd2
  } glyph_class_t;

  typedef struct packed {
    logic [1:0]          pend;
    logic                skip;
    logic [PartialW-1:0] partial;
  } dec_state_t;

  typedef struct packed {
    logic [CpW-1:0]    a_first;
    logic [CountW-1:0] a_count;
    logic [CpW-1:0]    b_first;
    logic [CountW-1:0] b_count;
  } strip_cfg_t;

endpackage

// ===== hw/rtl/ugsd_utf8_dec.sv =====
// ----------------------------------------------------------------------------
// ugsd_utf8_dec
// Byte-wise UTF-8 sequence tracker; emits one registered nonzero code point
// per completed sequence of one to three bytes.
// ----------------------------------------------------------------------------
module ugsd_utf8_dec (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_byte_value,
  output logic                      cp_valid,
  input  logic                      cp_ready,
  output logic [ugsd_pkg::CpW-1:0]  cp_value
);

  ugsd_pkg::dec_state_t st_r, st_nxt;
  logic                     cp_vld_r, cp_vld_nxt;
  logic [ugsd_pkg::CpW-1:0] cp_r, cp_nxt;
  logic                     accept;
  logic                     emit;
  logic [ugsd_pkg::CpW-1:0] emit_cp;
  logic [ugsd_pkg::CpW-1:0] acc;
  logic [1:0]               pend_dec;
  logic                     is_cont;

  assign in_ready = !cp_vld_r || cp_ready;
  assign accept   = in_valid && in_ready;
  assign cp_valid = cp_vld_r;
  assign cp_value = cp_r;

  assign is_cont  = (in_byte_value & ugsd_pkg::CONT_MASK) == ugsd_pkg::CONT_TAG;
  assign pend_dec = st_r.pend - 2'd1;
  assign acc      = {st_r.partial, in_byte_value[5:0]};

  always_comb begin
    st_nxt  = st_r;
    emit    = 1'b0;
    emit_cp = acc;
    if (in_byte_value == 8'h00) begin
      st_nxt = '0;
    end else if (st_r.skip) begin
      st_nxt.pend = pend_dec;
      st_nxt.skip = (pend_dec != 2'd0);
    end else if (st_r.pend != 2'd0 && is_cont) begin
      st_nxt.pend = pend_dec;
      if (pend_dec == 2'd0) begin
        st_nxt.partial = '0;
        emit           = (acc != '0);
      end else begin
        st_nxt.partial = acc[ugsd_pkg::PartialW-1:0];
      end
    end else begin
      // Nothing pending, or a broken sequence: start over on this byte.
      st_nxt = '0;
      if (in_byte_value < ugsd_pkg::CONT_TAG) begin
        emit    = 1'b1;
        emit_cp = {8'h00, in_byte_value};
      end else if (in_byte_value < ugsd_pkg::LEAD2_BASE) begin
        emit = 1'b0;
      end else if (in_byte_value < ugsd_pkg::LEAD3_BASE) begin
        st_nxt.partial = {5'd0, in_byte_value[4:0]};
        st_nxt.pend    = 2'd1;
      end else if (in_byte_value < ugsd_pkg::LEAD4_BASE) begin
        st_nxt.partial = {6'd0, in_byte_value[3:0]};
        st_nxt.pend    = 2'd2;
      end else begin
        st_nxt.skip = 1'b1;
        st_nxt.pend = 2'd3;
      end
    end
  end

  always_comb begin
    cp_vld_nxt = cp_vld_r;
    cp_nxt     = cp_r;
    if (accept) begin
      cp_vld_nxt = emit;
      cp_nxt     = emit_cp;
    end else if (cp_ready) begin
      cp_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= '0;
      cp_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        st_r <= st_nxt;
      end
      cp_vld_r <= cp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_r <= cp_nxt;
  end

  a_skip_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.skip |-> st_r.pend != 2'd0)
    else $error("skip mode with no bytes left to skip");

  a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_byte_value == 8'h00) |=> (st_r == '0 && !cp_vld_r))
    else $error("terminator did not clear decoder state");

  a_no_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
    cp_vld_r |-> cp_r != '0)
    else $error("zero code point emitted");

endmodule

// ===== hw/rtl/ugsd_classify.sv =====
// ----------------------------------------------------------------------------
// ugsd_classify
// Holds the strip configuration and maps each code point to a glyph class
// (strip A, strip B or unsupported) and an index, into the result register.
// ----------------------------------------------------------------------------
module ugsd_classify (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ugsd_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [ugsd_pkg::CfgDataW-1:0]   cfg_wdata,
  input  logic                            cp_valid,
  output logic                            cp_ready,
  input  logic [ugsd_pkg::CpW-1:0]        cp_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ugsd_pkg::CpW-1:0]        out_code_point,
  output logic [1:0]                      out_glyph_class,
  output logic [ugsd_pkg::IndexW-1:0]     out_glyph_index
);

  ugsd_pkg::strip_cfg_t cfg_r;
  logic                          out_vld_r, out_vld_nxt;
  logic [ugsd_pkg::CpW-1:0]      cp_r;
  ugsd_pkg::glyph_class_t        cls_r, cls_nxt;
  logic [ugsd_pkg::IndexW-1:0]   idx_r, idx_nxt;
  logic [ugsd_pkg::CountW-1:0]   a_n, b_n;
  logic [ugsd_pkg::CpW:0]        a_end, b_end;
  logic [ugsd_pkg::CpW-1:0]      a_off, b_off;
  logic                          in_a, in_b;
  logic                          take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.a_first <= ugsd_pkg::STRIP_A_FIRST_RST;
      cfg_r.a_count <= ugsd_pkg::STRIP_A_COUNT_RST;
      cfg_r.b_first <= ugsd_pkg::STRIP_B_FIRST_RST;
      cfg_r.b_count <= ugsd_pkg::STRIP_B_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ugsd_pkg::CFG_STRIP_A_FIRST: cfg_r.a_first <= cfg_wdata;
        ugsd_pkg::CFG_STRIP_A_COUNT: cfg_r.a_count <= cfg_wdata[ugsd_pkg::CountW-1:0];
        ugsd_pkg::CFG_STRIP_B_FIRST: cfg_r.b_first <= cfg_wdata;
        ugsd_pkg::CFG_STRIP_B_COUNT: cfg_r.b_count <= cfg_wdata[ugsd_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // Counts above the strip limit behave as the limit; the end bound is one
  // bit wider so a strip reaching past the top of the code space is exact.
  assign a_n   = (cfg_r.a_count > ugsd_pkg::STRIP_MAX) ? ugsd_pkg::STRIP_MAX : cfg_r.a_count;
  assign b_n   = (cfg_r.b_count > ugsd_pkg::STRIP_MAX) ? ugsd_pkg::STRIP_MAX : cfg_r.b_count;
  assign a_end = {1'b0, cfg_r.a_first} + {8'd0, a_n};
  assign b_end = {1'b0, cfg_r.b_first} + {8'd0, b_n};
  assign in_a  = (cp_value >= cfg_r.a_first) && ({1'b0, cp_value} < a_end);
  assign in_b  = (cp_value >= cfg_r.b_first) && ({1'b0, cp_value} < b_end);
  assign a_off = cp_value - cfg_r.a_first;
  assign b_off = cp_value - cfg_r.b_first;

  always_comb begin
    priority if (in_a) begin
      cls_nxt = ugsd_pkg::CLS_STRIP_A;
      idx_nxt = a_off[ugsd_pkg::IndexW-1:0];
    end else if (in_b) begin
      cls_nxt = ugsd_pkg::CLS_STRIP_B;
      idx_nxt = b_off[ugsd_pkg::IndexW-1:0];
    end else begin
      cls_nxt = ugsd_pkg::CLS_UNSUP;
      idx_nxt = '0;
    end
  end

  assign cp_ready = !out_vld_r || out_ready;
  assign take     = cp_valid && cp_ready;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (take) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cp_r  <= cp_value;
      cls_r <= cls_nxt;
      idx_r <= idx_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_code_point  = cp_r;
  assign out_glyph_class = cls_r;
  assign out_glyph_index = idx_r;

  a_unsup_zero_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && cls_r == ugsd_pkg::CLS_UNSUP) |-> idx_r == '0)
    else $error("unsupported glyph with nonzero index");

  a_strip_a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && cls_r == ugsd_pkg::CLS_STRIP_A) |-> cp_r >= cfg_r.a_first)
    else $error("strip A result below its first code point");

  a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (out_vld_r && cp_r == $past(cp_value)))
    else $error("accepted code point not loaded into result register");

endmodule

// ===== hw/rtl/utf8_glyph_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_glyph_stream_decoder
// UTF-8 byte stream to 16-bit code point decoder with glyph strip lookup.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake          Payload
//   in_      input      valid / ready      byte_value[7:0]
//   out_     output     valid / ready      code_point[15:0], glyph_class[1:0],
//                                          glyph_index[7:0]
//   cfg_     input      write enable only  index[1:0], wdata[15:0]
//
// One byte is accepted per cycle while in_ready is high. The code point of the
// byte that completes a sequence is held in the decode register, then in the
// result register. Each stage refills in the cycle it drains, so stalls on
// out_ready only back up through the two registers to in_ready. Reset is
// synchronous and restores the default strip setup; no clearing pass is needed.
// ----------------------------------------------------------------------------
module utf8_glyph_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_code_point,
  output logic [1:0]  out_glyph_class,
  output logic [7:0]  out_glyph_index,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic                     cp_valid;
  logic                     cp_ready;
  logic [ugsd_pkg::CpW-1:0] cp_value;

  ugsd_utf8_dec u_dec (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte_value (in_byte_value),
    .cp_valid      (cp_valid),
    .cp_ready      (cp_ready),
    .cp_value      (cp_value)
  );

  ugsd_classify u_cls (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .cp_valid        (cp_valid),
    .cp_ready        (cp_ready),
    .cp_value        (cp_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_code_point  (out_code_point),
    .out_glyph_class (out_glyph_class),
    .out_glyph_index (out_glyph_index)
  );

endmodule
